// File: design/mexp_pkg.sv
// Shared widths, command and status types of the modular exponentiation block.
package mexp_pkg;

	localparam int BASE_W = 63;
	localparam int EXP_W  = 63;
	localparam int MOD_W  = 31;
	localparam int CNT_W  = 6;

	localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(BASE_W - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_W - 1);

	typedef struct packed {
		logic load;
		logic red_step;
		logic setup;
		logic mul_clear;
		logic mul_step;
		logic mul_last;
	} mexp_cmd_t;

	typedef struct packed {
		logic zero;
		logic exp_zero;
	} mexp_stat_t;

endpackage

// File: design/modular_exponentiation.sv
// The 63-step base reduction comes first; when the modulus or base mod modulus is
// zero the result is zero, otherwise one bit-serial multiply pass over the 31
// multiplier bits runs per exponent bit (square and product run side by side).
// One item at a time: the next beat is taken the cycle after the result leaves.
// arst_n clears the controller to idle; datapath registers are not reset.
module modular_exponentiation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mexp_pkg::BASE_W-1:0] base,
	input  logic [mexp_pkg::EXP_W-1:0]  exponent,
	input  logic [mexp_pkg::MOD_W-1:0]  modulus,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mexp_pkg::MOD_W-1:0]  result
);
	import mexp_pkg::*;

	mexp_cmd_t  cmd;
	mexp_stat_t stat;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mexp_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.base     (base),
		.exponent (exponent),
		.modulus  (modulus),
		.stat     (stat),
		.result   (result)
	);

endmodule

// File: design/mexp_dp.sv
// Datapath: base reduction, two bit-serial modular multipliers, exponent shifter.
module mexp_dp (
	input  logic                        clk,
	input  mexp_pkg::mexp_cmd_t         cmd,
	input  logic [mexp_pkg::BASE_W-1:0] base,
	input  logic [mexp_pkg::EXP_W-1:0]  exponent,
	input  logic [mexp_pkg::MOD_W-1:0]  modulus,
	output mexp_pkg::mexp_stat_t        stat,
	output logic [mexp_pkg::MOD_W-1:0]  result
);
	import mexp_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic [EXP_W-1:0]  exp_q;
	logic [MOD_W-1:0]  mod_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  sq_q;
	logic [MOD_W-1:0]  ra_q;
	logic [MOD_W-1:0]  rb_q;
	logic [MOD_W-1:0]  ma_q;
	logic [MOD_W-1:0]  mb_q;

	logic [MOD_W:0]    red_t;
	logic [MOD_W-1:0]  red_next;
	logic [MOD_W-1:0]  ra_next;
	logic [MOD_W-1:0]  rb_next;

	// One step of r = (2r + bit*b) mod m, with r < m and b < m.
	function automatic logic [MOD_W-1:0] mm_step(input logic [MOD_W-1:0] r,
		input logic bit_i, input logic [MOD_W-1:0] b, input logic [MOD_W-1:0] m);
		logic [MOD_W+1:0] t;
		logic [MOD_W+1:0] t1;
		logic [MOD_W+1:0] t2;
		logic [MOD_W+1:0] m1;
		logic [MOD_W+1:0] m2;
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t  = {1'b0, r, 1'b0} + (bit_i ? {2'b00, b} : '0);
		t1 = t - m1;
		t2 = t - m2;
		if (t >= m2) begin
			mm_step = t2[MOD_W-1:0];
		end else if (t >= m1) begin
			mm_step = t1[MOD_W-1:0];
		end else begin
			mm_step = t[MOD_W-1:0];
		end
	endfunction

	// Restoring reduction: shift in one base bit, subtract the modulus if it fits.
	always_comb begin
		red_t = {sq_q, base_q[BASE_W-1]};
		if (red_t >= {1'b0, mod_q}) begin
			red_t = red_t - {1'b0, mod_q};
		end
		red_next = red_t[MOD_W-1:0];
	end

	assign ra_next = mm_step(ra_q, ma_q[MOD_W-1], sq_q, mod_q);
	assign rb_next = mm_step(rb_q, mb_q[MOD_W-1], sq_q, mod_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exponent;
			mod_q  <= modulus;
			sq_q   <= '0;
		end
		if (cmd.red_step) begin
			sq_q   <= red_next;
			base_q <= {base_q[BASE_W-2:0], 1'b0};
		end
		if (cmd.setup) begin
			acc_q <= stat.zero ? '0 : MOD_W'(1);
		end
		if (cmd.mul_clear) begin
			ra_q <= '0;
			rb_q <= '0;
			ma_q <= acc_q;
			mb_q <= sq_q;
		end
		if (cmd.mul_step) begin
			ra_q <= ra_next;
			rb_q <= rb_next;
			ma_q <= {ma_q[MOD_W-2:0], 1'b0};
			mb_q <= {mb_q[MOD_W-2:0], 1'b0};
			// commit the square, and the product if the exponent bit is set, on the last multiplier bit
			if (cmd.mul_last) begin
				if (exp_q[0]) begin
					acc_q <= ra_next;
				end
				sq_q  <= rb_next;
				exp_q <= {1'b0, exp_q[EXP_W-1:1]};
			end
		end
	end

	assign stat.zero     = (mod_q == '0) || (sq_q == '0);
	assign stat.exp_zero = (exp_q == '0);
	assign result        = acc_q;

endmodule

// File: design/mexp_ctrl.sv
// Controller: sequences reduction, per-bit multiply passes and the result beat.
module mexp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  mexp_pkg::mexp_stat_t stat,
	output mexp_pkg::mexp_cmd_t  cmd
);
	import mexp_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_REDUCE = 6'b000010,
		S_SETUP  = 6'b000100,
		S_TEST   = 6'b001000,
		S_MUL    = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = RED_LAST;
					state_d  = S_REDUCE;
				end
			end
			S_REDUCE: begin
				cmd.red_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_SETUP;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = stat.zero ? S_DONE : S_TEST;
			end
			S_TEST: begin
				if (stat.exp_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_clear = 1'b1;
					cnt_d         = MUL_LAST;
					state_d       = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == '0) begin
					cmd.mul_last = 1'b1;
					state_d      = S_TEST;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_DONE: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);

endmodule

// File: design/mexp_chk.sv
// Port-level checker for the modular exponentiation block, bound to the top level.
module mexp_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mexp_pkg::MOD_W-1:0]  result
);
	import mexp_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("result beat changed while stalled");

	// no input beat while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// an accepted item never yields a result in the next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result appeared right after input beat");

	// one result per item: a taken result is not followed at once by another
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("repeated result beat");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result)
);
